// ===== rtl/rbe_pkg.sv =====
// ----------------------------------------------------------------------------
// rbe_pkg: shared types, constants and tables for the BCD-to-epoch converter
// Field widths, time weights and the cumulative day-of-year table.
// ----------------------------------------------------------------------------
package rbe_pkg;

  localparam int unsigned SEC_W   = 7;
  localparam int unsigned MIN_W   = 7;
  localparam int unsigned HOUR_W  = 6;
  localparam int unsigned DAY_W   = 6;
  localparam int unsigned MONTH_W = 5;
  localparam int unsigned YEAR_W  = 8;
  localparam int unsigned EPOCH_W = 32;

  // Day count since 1970 stays below 2^17 for every input pattern
  localparam int unsigned DAYS_W  = 17;

  localparam int unsigned YEAR_BASE    = 30;  // 2000 less 1970
  localparam int unsigned DAYS_PER_YR  = 365;
  localparam int unsigned SEC_PER_MIN  = 60;
  localparam int unsigned SEC_PER_HOUR = 60 * SEC_PER_MIN;
  localparam int unsigned SEC_PER_DAY  = 24 * SEC_PER_HOUR;

  localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
  localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
  localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);

  // Decoded calendar reading, binary per field
  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   mday;
    logic [HOUR_W-1:0]  hour;
    logic [MIN_W-1:0]   minute;
    logic [SEC_W-1:0]   second;
  } cal_t;

  // Days before the given month (0 = January), February taken as 29 days
  function automatic logic [8:0] days_before(input logic [3:0] mon_idx);
    logic [8:0] d;
    case (mon_idx)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd60;
      4'd3:    d = 9'd91;
      4'd4:    d = 9'd121;
      4'd5:    d = 9'd152;
      4'd6:    d = 9'd182;
      4'd7:    d = 9'd213;
      4'd8:    d = 9'd244;
      4'd9:    d = 9'd274;
      4'd10:   d = 9'd305;
      4'd11:   d = 9'd335;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

// ===== rtl/rbe_bcd_decode.sv =====
// ----------------------------------------------------------------------------
// rbe_bcd_decode: packed BCD field to binary
// Low nibble plus ten times high nibble; nibbles above nine are not checked.
// ----------------------------------------------------------------------------
module rbe_bcd_decode #(
  parameter int unsigned W = rbe_pkg::SEC_W
) (
  input  logic [W-1:0] bcd,
  output logic [W-1:0] bin
);

  logic [W+3:0] lo_ext;
  logic [W+3:0] hi_ext;
  logic [W+3:0] sum;

  assign lo_ext = (W+4)'(bcd[3:0]);
  assign hi_ext = (W+4)'(bcd[W-1:4]);
  // x10 as x8 + x2
  assign sum    = lo_ext + (hi_ext << 3) + (hi_ext << 1);
  assign bin    = sum[W-1:0];

endmodule

// ===== rtl/rbe_epoch_calc.sv =====
// ----------------------------------------------------------------------------
// rbe_epoch_calc: decoded calendar reading to seconds since 1970
// Day count first, then one constant scale to seconds plus time of day.
// ----------------------------------------------------------------------------
module rbe_epoch_calc (
  input  rbe_pkg::cal_t                      cal,
  output logic [rbe_pkg::EPOCH_W-1:0]        epoch
);

  localparam int unsigned DW = rbe_pkg::DAYS_W;
  localparam int unsigned EW = rbe_pkg::EPOCH_W;

  logic [DW-1:0] yr;
  logic [DW-1:0] yr_p1;
  logic [DW-1:0] yr_p2;
  logic [DW-1:0] leap_days;
  logic          mon_ok;
  logic [3:0]    mon_idx;
  logic [DW-1:0] mon_days;
  logic [DW-1:0] feb_corr;
  logic [DW-1:0] days;
  logic [EW-1:0] day_secs;
  logic [EW-1:0] tod_secs;

  assign yr        = DW'(cal.year) + DW'(rbe_pkg::YEAR_BASE);
  assign yr_p1     = yr + DW'(1);
  assign yr_p2     = yr + DW'(2);
  assign leap_days = yr_p1 >> 2;

  assign mon_ok    = (cal.month >= rbe_pkg::MONTH_JAN) && (cal.month <= rbe_pkg::MONTH_DEC);
  assign mon_idx   = 4'(cal.month - rbe_pkg::MONTH_JAN);
  assign mon_days  = mon_ok ? DW'(rbe_pkg::days_before(mon_idx)) : '0;
  // table assumes 29 February: take a day back past February in common years
  assign feb_corr  = (mon_ok && (cal.month > rbe_pkg::MONTH_FEB) && (yr_p2[1:0] != 2'd0))
                     ? DW'(1) : '0;

  // day of month zero lands one day back; yr >= 30 keeps this positive
  assign days      = DW'(yr * DW'(rbe_pkg::DAYS_PER_YR)) + leap_days + mon_days
                     - feb_corr + DW'(cal.mday) - DW'(1);

  assign day_secs  = EW'(EW'(days) * EW'(rbe_pkg::SEC_PER_DAY));
  assign tod_secs  = EW'(EW'(cal.hour) * EW'(rbe_pkg::SEC_PER_HOUR))
                     + EW'(EW'(cal.minute) * EW'(rbe_pkg::SEC_PER_MIN))
                     + EW'(cal.second);
  assign epoch     = day_secs + tod_secs;

endmodule

// ===== rtl/rtc_bcd_to_epoch_seconds.sv =====
// ----------------------------------------------------------------------------
// rtc_bcd_to_epoch_seconds: RTC BCD reading to Unix epoch seconds
// Two-register pipeline: decoded input register, then result register.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel takes one RTC reading per request as six packed-BCD
//   fields (second, minute, hour, day, month, two-digit year 2000-2099).
//   The result channel returns one 32-bit count of seconds since
//   1970-01-01 00:00:00 per request, in order.
//   A request goes through the input register, then the result register,
//   which drives out_valid. Fields are BCD-decoded into the input register;
//   day count and scaling to seconds sit between the two registers.
//   Throughput is one request per cycle while results are taken, set by
//   the two-stage pipeline. Reset (rst_n low, synchronous) empties both
//   stages; out_valid drops. When the receiver stalls the result register
//   holds; the input stage still takes one more request, then in_ready
//   falls until the result is taken. Out-of-range fields are weighted as
//   given, a month outside 1-12 adds no month days; sum wraps modulo 2^32.
// ----------------------------------------------------------------------------
module rtc_bcd_to_epoch_seconds (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [rbe_pkg::SEC_W-1:0]    in_second_bcd,
  input  logic [rbe_pkg::MIN_W-1:0]    in_minute_bcd,
  input  logic [rbe_pkg::HOUR_W-1:0]   in_hour_bcd,
  input  logic [rbe_pkg::DAY_W-1:0]    in_day_bcd,
  input  logic [rbe_pkg::MONTH_W-1:0]  in_month_bcd,
  input  logic [rbe_pkg::YEAR_W-1:0]   in_year_bcd,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [rbe_pkg::EPOCH_W-1:0]  out_epoch_seconds
);

  rbe_pkg::cal_t                 cal_nxt;
  rbe_pkg::cal_t                 cal_r;
  logic                          s1_valid_r;
  logic                          out_valid_r;
  logic [rbe_pkg::EPOCH_W-1:0]   epoch_nxt;
  logic [rbe_pkg::EPOCH_W-1:0]   epoch_r;
  logic                          s2_en;
  logic                          in_acc;

  rbe_bcd_decode #(.W(rbe_pkg::SEC_W)) u_dec_sec (
    .bcd(in_second_bcd), .bin(cal_nxt.second)
  );
  rbe_bcd_decode #(.W(rbe_pkg::MIN_W)) u_dec_min (
    .bcd(in_minute_bcd), .bin(cal_nxt.minute)
  );
  rbe_bcd_decode #(.W(rbe_pkg::HOUR_W)) u_dec_hour (
    .bcd(in_hour_bcd), .bin(cal_nxt.hour)
  );
  rbe_bcd_decode #(.W(rbe_pkg::DAY_W)) u_dec_day (
    .bcd(in_day_bcd), .bin(cal_nxt.mday)
  );
  rbe_bcd_decode #(.W(rbe_pkg::MONTH_W)) u_dec_month (
    .bcd(in_month_bcd), .bin(cal_nxt.month)
  );
  rbe_bcd_decode #(.W(rbe_pkg::YEAR_W)) u_dec_year (
    .bcd(in_year_bcd), .bin(cal_nxt.year)
  );

  rbe_epoch_calc u_calc (
    .cal  (cal_r),
    .epoch(epoch_nxt)
  );

  // result register free, or emptied this cycle
  assign s2_en    = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || s2_en;
  assign in_acc   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s2_en) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cal_r <= cal_nxt;
    end
    if (s2_en && s1_valid_r) begin
      epoch_r <= epoch_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_epoch_seconds = epoch_r;

`ifndef SYNTHESIS
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s2_en |=> out_valid)
    else $error("decoded request lost between stages");

  a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid && !out_ready |-> !in_ready)
    else $error("request accepted while pipeline full and stalled");

  a_drain_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_epoch_seconds))
    else $error("stalled result register changed");
`endif

endmodule
